[hw/rtl/wncs_pkg.sv]
// Shared types and constants for the windowed normalized correlation spike block.
// No dependencies; imported by every module of the block but wncs_sqrt.
package wncs_pkg;

	// Request codes on req_type
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_BYTE = 1'b1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_ROW_BYTES  = 3'd0,
		CFG_WIN_COL    = 3'd1,
		CFG_WIN_ROW    = 3'd2,
		CFG_WIN_WIDTH  = 3'd3,
		CFG_WIN_HEIGHT = 3'd4,
		CFG_RF_MEAN    = 3'd5,
		CFG_RF_MAG     = 3'd6,
		CFG_THR_RATE   = 3'd7
	} cfg_idx_t;

	// Shared multiplier operations; the first six run in this order at frame end
	typedef enum logic [2:0] {
		MOP_M_SY = 3'd0,
		MOP_N_M  = 3'd1,
		MOP_R_SY = 3'd2,
		MOP_M_SR = 3'd3,
		MOP_NM_M = 3'd4,
		MOP_NM_R = 3'd5,
		MOP_A_B  = 3'd6,
		MOP_THR  = 3'd7
	} mul_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_MUL,
		ST_SQA_GO,
		ST_SQA_WAIT,
		ST_SQB_GO,
		ST_SQB_WAIT,
		ST_AB,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_ACT,
		ST_THR,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic    accept;
		logic    div_go;
		logic    div_mean;
		logic    mean_latch;
		logic    mul_go;
		mul_op_t mul_op;
		logic    sqa_go;
		logic    sqb_go;
		logic    sqa_latch;
		logic    act_latch;
		logic    push;
	} cmd_t;

	typedef struct packed {
		logic sq_busy;
		logic div_busy;
		logic zero_div;
		logic out_busy;
	} status_t;

	localparam int ACC_W     = 48;
	localparam int DIV_NUM_W = 75;
	localparam int DIV_DEN_W = 60;
	localparam int DIV_Q_W   = 17;
	localparam int PROD_W    = 60;

	localparam logic [6:0] MEAN_ITERS = 7'd40;
	localparam logic [6:0] CORR_ITERS = 7'd75;
	localparam logic [DIV_Q_W-1:0] Q_SAT = 17'd65536;

endpackage

[hw/rtl/wncs_sqrt.sv]
// Bit-serial integer square root, one result bit per cycle.
// Depends on nothing but its ports.
module wncs_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        busy,
	output logic [31:0] root
);
	logic [63:0] v_q, r_q, b_q;
	logic        busy_q;
	logic [63:0] rb;

	assign rb   = r_q + b_q;
	assign busy = busy_q;
	assign root = r_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (busy_q && b_q[0]) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= value;
			r_q <= '0;
			b_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (v_q >= rb) begin
				v_q <= v_q - rb;
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end
endmodule

[hw/rtl/wncs_div.sv]
// Restoring divider, one quotient bit per cycle, quotient saturated at 65536.
// Uses wncs_pkg widths.
module wncs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wncs_pkg::DIV_NUM_W-1:0]  num,
	input  logic [wncs_pkg::DIV_DEN_W-1:0]  den,
	input  logic [6:0]                      iters,
	output logic                            busy,
	output logic [wncs_pkg::DIV_Q_W-1:0]    quot
);
	import wncs_pkg::*;

	logic [DIV_NUM_W-1:0] nr_q;
	logic [DIV_DEN_W-1:0] rem_q, den_q, rem_d;
	logic [DIV_Q_W-1:0]   q_q, q_d;
	logic [6:0]           cnt_q;
	logic                 busy_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 ge;
	logic [DIV_Q_W:0]     q_wide;

	always_comb begin
		trial  = {rem_q, nr_q[DIV_NUM_W-1]};
		ge     = trial >= {1'b0, den_q};
		rem_d  = ge ? DIV_DEN_W'(trial - {1'b0, den_q}) : DIV_DEN_W'(trial);
		q_wide = {q_q, ge};
		q_d    = (q_wide > {1'b0, Q_SAT}) ? Q_SAT : q_wide[DIV_Q_W-1:0];
	end

	assign busy = busy_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= iters;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nr_q  <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			nr_q  <= nr_q << 1;
			rem_q <= rem_d;
			q_q   <= q_d;
		end
	end
endmodule

[hw/rtl/wncs_dp.sv]
// Datapath: config registers, template store, frame accumulators, shared
// multiplier, frame-end math and result register. Uses wncs_pkg, wncs_sqrt, wncs_div.
module wncs_dp #(
	parameter int TEMPLATE_DEPTH = 4096,
	parameter int MAX_ROW_BYTES  = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wncs_pkg::cmd_t        cmd,
	output wncs_pkg::status_t     st,
	input  logic                  cfg_valid,
	input  logic [2:0]            cfg_index,
	input  logic [35:0]           cfg_data,
	input  logic                  req_type,
	input  logic [11:0]           rf_index,
	input  logic [7:0]            rf_value,
	input  logic [7:0]            pixel_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [15:0]    activation,
	output logic                  spike,
	output logic [15:0]           threshold_after
);
	import wncs_pkg::*;

	localparam int AW = (TEMPLATE_DEPTH > 1) ? $clog2(TEMPLATE_DEPTH) : 1;
	localparam int CW = $clog2(MAX_ROW_BYTES);
	localparam int PW = ((CW > 13) ? CW : 13) + 1;
	localparam logic [PW-1:0] MAX_RB = PW'(MAX_ROW_BYTES);
	localparam logic [16:0]   DEPTH17 = 17'(TEMPLATE_DEPTH);

	// config
	logic [12:0] row_bytes_q;
	logic [10:0] win_col_q, win_row_q;
	logic [6:0]  win_width_q, win_height_q;
	logic [15:0] rf_mean_q, thr_rate_q;
	logic [35:0] rf_mag_q;

	// frame state
	logic [31:0]   fsum_q;
	logic [23:0]   fcnt_q;
	logic [19:0]   ysum_q, rsum_q;
	logic [27:0]   yysum_q, xsum_q;
	logic [12:0]   pcnt_q;
	logic [11:0]   row_q;
	logic [CW-1:0] col_q;
	logic [15:0]   thr_q;

	// byte stage
	logic       hit_s1, tok_s1;
	logic [7:0] pix_s1, rd_s1;
	logic [7:0] tmem [TEMPLATE_DEPTH];

	// frame-end registers
	logic [15:0]             m_q;
	logic [28:0]             nm_q;
	logic [27:0]             a_q;
	logic signed [ACC_W-1:0] f_q, x_q;
	logic [PROD_W-1:0]       p_s1;
	mul_op_t                 op_s1;
	logic                    pv_s1;
	logic signed [15:0]      act_q;
	logic                    spk_q;
	logic                    out_valid_q;
	logic signed [15:0]      act_out_q;
	logic                    spk_out_q;
	logic [15:0]             thr_out_q;

	// window geometry
	logic [PW-1:0] rb, rb_raw, col_ext, c0_ext, cdiff;
	logic [6:0]    ww, wh;
	logic [11:0]   c0, rdiff;
	logic          row_hit, col_hit, win_hit, byte_acc, load_we;
	logic [12:0]   tidx;
	logic          tidx_ok;
	logic [7:0]    tv;

	always_comb begin
		rb_raw  = PW'(row_bytes_q);
		rb      = (rb_raw < PW'(2)) ? PW'(2) : ((rb_raw > MAX_RB) ? MAX_RB : rb_raw);
		ww      = (win_width_q > 7'd64) ? 7'd64 : win_width_q;
		wh      = (win_height_q > 7'd64) ? 7'd64 : win_height_q;
		c0      = {win_col_q, 1'b0};
		col_ext = PW'(col_q);
		c0_ext  = PW'(c0);
		row_hit = (row_q >= {1'b0, win_row_q}) &&
		          ({1'b0, row_q} < ({2'b0, win_row_q} + {6'b0, wh}));
		col_hit = (col_ext >= c0_ext) && (col_ext < c0_ext + PW'({ww, 1'b0})) && !col_q[0];
		win_hit = row_hit && col_hit;
		rdiff   = row_q - {1'b0, win_row_q};
		cdiff   = col_ext - c0_ext;
		tidx    = 13'(rdiff[5:0]) * 13'(ww) + 13'(cdiff[6:1]);
		tidx_ok = {4'b0, tidx} < DEPTH17;
		byte_acc = cmd.accept && (req_type == REQ_BYTE);
		load_we  = cmd.accept && (req_type == REQ_LOAD) && ({5'b0, rf_index} < DEPTH17);
		tv       = tok_s1 ? rd_s1 : 8'd0;
	end

	// template store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (load_we) begin
			tmem[AW'(rf_index)] <= rf_value;
		end
		if (byte_acc) begin
			rd_s1 <= tmem[AW'(tidx)];
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc) begin
			pix_s1 <= pixel_byte;
			tok_s1 <= tidx_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q  <= 13'd1280;
			win_col_q    <= '0;
			win_row_q    <= '0;
			win_width_q  <= 7'd8;
			win_height_q <= 7'd8;
			rf_mean_q    <= '0;
			rf_mag_q     <= '0;
			thr_rate_q   <= 16'd6554;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_ROW_BYTES:  row_bytes_q  <= cfg_data[12:0];
				CFG_WIN_COL:    win_col_q    <= cfg_data[10:0];
				CFG_WIN_ROW:    win_row_q    <= cfg_data[10:0];
				CFG_WIN_WIDTH:  win_width_q  <= cfg_data[6:0];
				CFG_WIN_HEIGHT: win_height_q <= cfg_data[6:0];
				CFG_RF_MEAN:    rf_mean_q    <= cfg_data[15:0];
				CFG_RF_MAG:     rf_mag_q     <= cfg_data;
				CFG_THR_RATE:   thr_rate_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// shared multiplier operand select
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [31:0] sq_root;

	always_comb begin
		case (cmd.mul_op)
			MOP_M_SY: begin mul_a = 32'(m_q);  mul_b = 32'(ysum_q); end
			MOP_N_M:  begin mul_a = 32'(pcnt_q); mul_b = 32'(m_q); end
			MOP_R_SY: begin mul_a = 32'(rf_mean_q); mul_b = 32'(ysum_q); end
			MOP_M_SR: begin mul_a = 32'(m_q);  mul_b = 32'(rsum_q); end
			MOP_NM_M: begin mul_a = 32'(nm_q); mul_b = 32'(m_q); end
			MOP_NM_R: begin mul_a = 32'(nm_q); mul_b = 32'(rf_mean_q); end
			MOP_A_B:  begin mul_a = 32'(a_q);  mul_b = sq_root; end
			MOP_THR: begin
				if (spk_q) begin
					mul_a = 32'(17'd65536 - {1'b0, thr_q});
					mul_b = 32'(thr_rate_q);
				end else begin
					mul_a = 32'(thr_q);
					mul_b = 32'(17'd65536 - {1'b0, thr_rate_q});
				end
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
		prod = mul_a * mul_b;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			p_s1  <= prod[PROD_W-1:0];
			op_s1 <= cmd.mul_op;
		end
	end

	// square root and divide units
	logic                    sq_busy, div_busy;
	logic [63:0]             sq_value;
	logic signed [ACC_W-1:0] f_pos, x_mag;
	logic [DIV_NUM_W-1:0]    div_num;
	logic [DIV_DEN_W-1:0]    div_den;
	logic [6:0]              div_iters;
	logic [DIV_Q_W-1:0]      quot;
	logic [39:0]             mean_num;

	always_comb begin
		f_pos    = (f_q < 0) ? '0 : f_q;
		x_mag    = (x_q < 0) ? -x_q : x_q;
		sq_value = cmd.sqb_go ? 64'({f_pos[46:0], 16'b0}) : 64'({rf_mag_q, 20'b0});
		mean_num = {fsum_q, 8'b0} + 40'(fcnt_q[23:1]);
		if (cmd.div_mean) begin
			div_num   = {mean_num, 35'b0};
			div_den   = DIV_DEN_W'(fcnt_q);
			div_iters = MEAN_ITERS;
		end else begin
			div_num   = {x_mag[45:0], 29'b0};
			div_den   = p_s1;
			div_iters = CORR_ITERS;
		end
	end

	wncs_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqa_go || cmd.sqb_go),
		.value  (sq_value),
		.busy   (sq_busy),
		.root   (sq_root)
	);

	wncs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_go),
		.num    (div_num),
		.den    (div_den),
		.iters  (div_iters),
		.busy   (div_busy),
		.quot   (quot)
	);

	// activation, spike, next threshold
	logic               zero_div;
	logic signed [15:0] act_c;
	logic               spike_c;
	logic [15:0]        thr_new;

	always_comb begin
		zero_div = (rf_mag_q == '0) || (f_q <= 0);
		if (zero_div) begin
			act_c = '0;
		end else if (x_q < 0) begin
			act_c = (quot >= 17'd32768) ? 16'sh8000 : -$signed(quot[15:0]);
		end else begin
			act_c = (quot >= 17'd32767) ? 16'sh7FFF : $signed(quot[15:0]);
		end
		spike_c = $signed({act_c[15], act_c, 1'b0}) > $signed({2'b0, thr_q});
		thr_new = spk_q ? (thr_q + p_s1[31:16]) : p_s1[31:16];
	end

	always_ff @(posedge clk) begin
		if (cmd.sqa_latch) begin
			a_q <= sq_root[27:0];
		end
		if (cmd.act_latch) begin
			act_q <= act_c;
			spk_q <= spike_c;
		end
		if (cmd.push) begin
			act_out_q <= act_q;
			spk_out_q <= spk_q;
			thr_out_q <= thr_new;
		end
		if (cmd.mean_latch) begin
			m_q <= quot[15:0];
			f_q <= $signed(ACC_W'({yysum_q, 16'b0}));
			x_q <= $signed(ACC_W'({xsum_q, 16'b0}));
		end else if (pv_s1) begin
			case (op_s1)
				MOP_M_SY: f_q <= f_q - $signed(ACC_W'({p_s1, 9'b0}));
				MOP_N_M:  nm_q <= p_s1[28:0];
				MOP_R_SY: x_q <= x_q - $signed(ACC_W'({p_s1, 8'b0}));
				MOP_M_SR: x_q <= x_q - $signed(ACC_W'({p_s1, 8'b0}));
				MOP_NM_M: f_q <= f_q + $signed(ACC_W'(p_s1));
				MOP_NM_R: x_q <= x_q + $signed(ACC_W'(p_s1));
				default: ;
			endcase
		end
	end

	// frame accumulators, positions, threshold, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsum_q      <= '0;
			fcnt_q      <= '0;
			ysum_q      <= '0;
			yysum_q     <= '0;
			xsum_q      <= '0;
			rsum_q      <= '0;
			pcnt_q      <= '0;
			row_q       <= '0;
			col_q       <= '0;
			thr_q       <= '0;
			hit_s1      <= 1'b0;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			hit_s1 <= byte_acc && win_hit;
			pv_s1  <= cmd.mul_go;
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.push) begin
				thr_q   <= thr_new;
				fsum_q  <= '0;
				fcnt_q  <= '0;
				ysum_q  <= '0;
				yysum_q <= '0;
				xsum_q  <= '0;
				rsum_q  <= '0;
				pcnt_q  <= '0;
				row_q   <= '0;
				col_q   <= '0;
			end else begin
				if (byte_acc) begin
					if (fcnt_q != 24'hFF_FFFF) begin
						fsum_q <= fsum_q + 32'(pixel_byte);
						fcnt_q <= fcnt_q + 24'd1;
					end
					if (col_ext + PW'(1) >= rb) begin
						col_q <= '0;
						if (row_q != 12'hFFF) begin
							row_q <= row_q + 12'd1;
						end
					end else begin
						col_q <= col_q + CW'(1);
					end
				end
				if (hit_s1) begin
					ysum_q  <= ysum_q + 20'(pix_s1);
					yysum_q <= yysum_q + 28'(16'(pix_s1) * 16'(pix_s1));
					xsum_q  <= xsum_q + 28'(16'(pix_s1) * 16'(tv));
					rsum_q  <= rsum_q + 20'(tv);
					pcnt_q  <= pcnt_q + 13'd1;
				end
			end
		end
	end

	assign st.sq_busy  = sq_busy;
	assign st.div_busy = div_busy;
	assign st.zero_div = zero_div;
	assign st.out_busy = out_valid_q && !out_ready;

	assign out_valid       = out_valid_q;
	assign activation      = act_out_q;
	assign spike           = spk_out_q;
	assign threshold_after = thr_out_q;

	a_pcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcnt_q <= 13'd4096)
		else $error("window pixel count past 64x64");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mean_latch |=> m_q <= 16'd65280)
		else $error("frame mean out of byte range");

	a_units_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_busy && div_busy))
		else $error("sqrt and divider overlap");
endmodule

[hw/rtl/wncs_ctrl.sv]
// Frame-end sequencer: takes bytes and loads while idle, then steps the datapath through
// mean, sums, two square roots and divide (unless zero_div), threshold. Uses wncs_pkg.
module wncs_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  req_type,
	input  logic                  frame_last,
	output logic                  in_ready,
	input  wncs_pkg::status_t     st,
	output wncs_pkg::cmd_t        cmd
);
	import wncs_pkg::*;

	localparam logic [2:0] MUL_LAST = 3'd5;
	localparam logic [2:0] MUL_DONE = 3'd6;

	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		in_ready   = 1'b0;
		cmd        = '0;
		cmd.mul_op = MOP_M_SY;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && (req_type == REQ_BYTE) && frame_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_MEAN_GO;
			ST_MEAN_GO: begin
				cmd.div_go   = 1'b1;
				cmd.div_mean = 1'b1;
				state_d      = ST_MEAN_WAIT;
			end
			ST_MEAN_WAIT: begin
				if (!st.div_busy) begin
					cmd.mean_latch = 1'b1;
					cnt_d          = '0;
					state_d        = ST_MUL;
				end
			end
			ST_MUL: begin
				cnt_d = cnt_q + 3'd1;
				if (cnt_q <= MUL_LAST) begin
					cmd.mul_go = 1'b1;
					cmd.mul_op = mul_op_t'(cnt_q);
				end
				if (cnt_q == MUL_DONE) begin
					state_d = st.zero_div ? ST_ACT : ST_SQA_GO;
				end
			end
			ST_SQA_GO: begin
				cmd.sqa_go = 1'b1;
				state_d    = ST_SQA_WAIT;
			end
			ST_SQA_WAIT: begin
				if (!st.sq_busy) begin
					cmd.sqa_latch = 1'b1;
					state_d       = ST_SQB_GO;
				end
			end
			ST_SQB_GO: begin
				cmd.sqb_go = 1'b1;
				state_d    = ST_SQB_WAIT;
			end
			ST_SQB_WAIT: begin
				if (!st.sq_busy) begin
					state_d = ST_AB;
				end
			end
			ST_AB: begin
				cmd.mul_go = 1'b1;
				cmd.mul_op = MOP_A_B;
				state_d    = ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_go = 1'b1;
				state_d    = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!st.div_busy) begin
					state_d = ST_ACT;
				end
			end
			ST_ACT: begin
				cmd.act_latch = 1'b1;
				state_d       = ST_THR;
			end
			ST_THR: begin
				cmd.mul_go = 1'b1;
				cmd.mul_op = MOP_THR;
				state_d    = ST_PUSH;
			end
			ST_PUSH: begin
				if (!st.out_busy) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

[hw/rtl/window_normalized_correlation_spike.sv]
// Top level of the windowed normalized correlation spike block.
// Depends on wncs_pkg, wncs_ctrl and wncs_dp (which holds wncs_sqrt and wncs_div).
//
// Load the template with req_type 0 beats (rf_index row major over the
// window), then stream YUYV frame bytes with req_type 1, marking the final
// byte with frame_last. Loads and bytes are taken one beat per clock while
// in_ready is high; each byte updates the frame sum/count and, for luma bytes
// inside the window, the luma, luma-squared, cross and template sums, with the
// template read from a registered two-port store in the cycle before the
// accumulate. The last byte starts the frame-end sequence, during which
// in_ready is low: a 40-step mean divide, six products on one shared 32x32
// multiplier, two 32-step square roots, the product of the roots, a 75-step
// correlation divide and the threshold update; the roots, their product and
// the correlation divide are skipped on zero_div. The result beat (activation
// Q1.15, spike, updated threshold) sits in an output register, so the next
// frame's bytes are taken while it waits for out_ready. The template store has
// no reset; entries read before being written are undefined. Configuration may
// be written between beats when no result is pending; cfg_ready is always high.
module window_normalized_correlation_spike #(
	parameter int TEMPLATE_DEPTH = 4096,
	parameter int MAX_ROW_BYTES  = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [35:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               req_type,
	input  logic [11:0]        rf_index,
	input  logic [7:0]         rf_value,
	input  logic [7:0]         pixel_byte,
	input  logic               frame_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] activation,
	output logic               spike,
	output logic [15:0]        threshold_after
);
	import wncs_pkg::*;

	cmd_t    cmd;
	status_t st;

	// register writes land in the cycle after cfg_valid, never stalled
	assign cfg_ready = 1'b1;

	wncs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.req_type   (req_type),
		.frame_last (frame_last),
		.in_ready   (in_ready),
		.st         (st),
		.cmd        (cmd)
	);

	wncs_dp #(
		.TEMPLATE_DEPTH (TEMPLATE_DEPTH),
		.MAX_ROW_BYTES  (MAX_ROW_BYTES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.st              (st),
		.cfg_valid       (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.rf_index        (rf_index),
		.rf_value        (rf_value),
		.pixel_byte      (pixel_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.activation      (activation),
		.spike           (spike),
		.threshold_after (threshold_after)
	);
endmodule
